### hdl/assert_macros.svh
// Assertion macros shared by the channel mixer RTL.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("channel mixer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("channel mixer assertion failed");

`endif

### hdl/cmm_pkg.sv
// Package of the channel mixer: widths, request and register codes, shared types
// and the output rounding function. Depends on nothing.
package cmm_pkg;

    localparam int CMM_DIM         = 16;
    localparam int CMM_MAX_IN      = 16;
    localparam int CMM_MAX_OUT     = 16;
    localparam int CMM_CNT_W       = 5;
    localparam int CMM_CH_W        = 4;
    localparam int CMM_SMP_W       = 24;
    localparam int CMM_COEF_W      = 16;
    localparam int CMM_PROD_W      = CMM_SMP_W + CMM_COEF_W;
    localparam int CMM_ACC_W       = 48;
    localparam int CMM_PADDR_W     = 4;
    localparam int CMM_PDATA_W     = 32;

    // Request codes.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_MAP    = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_IN_CH  = 2'd0;
    localparam logic [1:0] REG_OUT_CH = 2'd1;
    localparam logic [1:0] REG_MAP_EN = 2'd2;

    localparam logic signed [CMM_SMP_W-1:0] SAT_HI = 24'sh7FFFFF;
    localparam logic signed [CMM_SMP_W-1:0] SAT_LO = 24'sh800000;

    typedef logic signed [CMM_ACC_W-1:0] acc_t;

    // Sample beat travelling down the cell chain.
    typedef struct packed {
        logic                          valid;
        logic                          clr;
        logic                          mac;
        logic [CMM_CH_W-1:0]           col;
        logic signed [CMM_SMP_W-1:0]   sample;
    } cmm_tok_t;

    // Coefficient write broadcast to all cells.
    typedef struct packed {
        logic                          en;
        logic [CMM_CH_W-1:0]           row;
        logic [CMM_CH_W-1:0]           col;
        logic signed [CMM_COEF_W-1:0]  value;
    } cmm_cwr_t;

    // Round half up from Q11.37 to Q1.23, then saturate to 24 bits.
    function automatic logic signed [CMM_SMP_W-1:0] cmm_round_sat(input acc_t acc);
        logic signed [CMM_ACC_W:0]      sum;
        logic signed [CMM_ACC_W-14:0]   q;
        logic signed [CMM_SMP_W-1:0]    res;
        sum = (CMM_ACC_W+1)'(acc) + (CMM_ACC_W+1)'(8192);
        q   = (CMM_ACC_W-13)'(sum >>> 14);
        if (q > (CMM_ACC_W-13)'(SAT_HI))
            res = SAT_HI;
        else if (q < (CMM_ACC_W-13)'(SAT_LO))
            res = SAT_LO;
        else
            res = q[CMM_SMP_W-1:0];
        return res;
    endfunction

endpackage

### hdl/cmm_if.sv
// Valid/ready channel interfaces of the channel mixer: request side and result side.
// Depends on cmm_pkg.
interface cmm_in_if
    import cmm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [CMM_CH_W-1:0]           in_channel;
    logic signed [CMM_SMP_W-1:0]   sample_value;
    logic [CMM_CH_W-1:0]           coef_row;
    logic [CMM_CH_W-1:0]           coef_col;
    logic signed [CMM_COEF_W-1:0]  coef_value;

    modport source (output valid, output req_type, output in_channel, output sample_value,
                    output coef_row, output coef_col, output coef_value, input ready);
    modport sink   (input valid, input req_type, input in_channel, input sample_value,
                    input coef_row, input coef_col, input coef_value, output ready);
endinterface

interface cmm_out_if
    import cmm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [CMM_CH_W-1:0]           out_channel;
    logic signed [CMM_SMP_W-1:0]   out_sample;
    logic                          last_out;

    modport source (output valid, output out_channel, output out_sample, output last_out,
                    input ready);
    modport sink   (input valid, input out_channel, input out_sample, input last_out,
                    output ready);
endinterface

### hdl/cmm_cell.sv
// One output row of the mixer: its coefficient column store, a registered MAC
// and its accumulator, which also rotates along the ring for readout. Depends on cmm_pkg.
module cmm_cell
    import cmm_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmm_tok_t               tok_in,
    output cmm_tok_t               tok_out,
    input  cmm_cwr_t               cwr,
    input  logic [CMM_CNT_W-1:0]   nout,
    input  logic                   rot,
    input  acc_t                   acc_in,
    output acc_t                   acc_out
);

    logic signed [CMM_COEF_W-1:0]  coef_mem [CMM_DIM];
    logic signed [CMM_PROD_W-1:0]  prod_reg;
    cmm_tok_t                      tok_reg;
    logic                          mac_reg;
    acc_t                          acc_reg;
    acc_t                          acc_next;
    acc_t                          acc_base;

    always_ff @(posedge clk)
    begin
        if (cwr.en && (cwr.row == CMM_CH_W'(INDEX)))
            coef_mem[cwr.col] <= cwr.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_mem[tok_in.col] * tok_in.sample;
        mac_reg  <= tok_in.mac && (CMM_CNT_W'(INDEX) < nout);
    end

    // A clearing beat zeroes every row; only rows below the output count add.
    always_comb
    begin
        acc_base = tok_reg.clr ? '0 : acc_reg;
        acc_next = acc_reg;
        if (rot)
            acc_next = acc_in;
        else if (tok_reg.valid)
            acc_next = acc_base + (mac_reg ? CMM_ACC_W'(prod_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;

endmodule

### hdl/channel_mixing_matrix_top.sv
// Top level of the audio channel mixer: APB registers, column map, request
// decode, the chain of MAC cells and the rounding output stage.
// Depends on cmm_pkg, cmm_if, cmm_cell and assert_macros.svh.
//
//  Channel | Direction | Handshake          | Beat contents
//  --------+-----------+--------------------+-------------------------------------------
//  din     | in        | valid/ready        | request type, channel, sample, coefficient
//  dout    | out       | valid/ready        | output channel, mixed sample, last flag
//  apb     | in        | psel/penable/pready| in_channels, out_channels, map_enable
//
// A sample beat is registered at launch and then walks the chain one cell per cycle
// (NCELL = min(MAX_OUT_CHANNELS, 16) cells); the last row's accumulator takes its product as the beat leaves the chain.
// The last channel of a frame adds a readout of the NCELL rows, longer while dout stalls.
// Write beats and ignored beats leave the request side ready. Reset zeroes the
// accumulators and the sequencer, sets both channel counts to one and clears map_enable;
// the coefficient and map stores keep no reset value. A stalled dout holds the rotation
// of the ring while an active row awaits output, and the request side waits until readout ends.
`include "assert_macros.svh"

module channel_mixing_matrix_top
    import cmm_pkg::*;
#(
    parameter int MAX_IN_CHANNELS  = CMM_MAX_IN,
    parameter int MAX_OUT_CHANNELS = CMM_MAX_OUT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    cmm_in_if.sink                   din,
    cmm_out_if.source                dout,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CMM_PADDR_W-1:0]   paddr,
    input  logic [CMM_PDATA_W-1:0]   pwdata,
    output logic [CMM_PDATA_W-1:0]   prdata,
    output logic                     pready
);

    // The ring holds one cell per output row that can ever be active.
    localparam int NCELL  = (MAX_OUT_CHANNELS < CMM_DIM) ? MAX_OUT_CHANNELS : CMM_DIM;
    localparam int LIM_IN = (MAX_IN_CHANNELS < CMM_DIM) ? MAX_IN_CHANNELS : CMM_DIM;
    localparam int CIW    = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [CMM_CNT_W-1:0] LIM_IN_C  = CMM_CNT_W'(LIM_IN);
    localparam logic [CMM_CNT_W-1:0] LIM_OUT_C = CMM_CNT_W'(NCELL);
    localparam logic [CIW-1:0]       RC_LAST   = CIW'(NCELL - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration registers. The APB write lands on the access phase.
    logic [CMM_CNT_W-1:0]  in_ch_reg;
    logic [CMM_CNT_W-1:0]  out_ch_reg;
    logic                  map_en_reg;
    logic                  apb_wr;
    logic [1:0]            apb_idx;

    assign pready  = 1'b1;
    assign apb_idx = paddr[3:2];
    assign apb_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg  <= CMM_CNT_W'(1);
            out_ch_reg <= CMM_CNT_W'(1);
            map_en_reg <= 1'b0;
        end
        else if (apb_wr)
        begin
            case (apb_idx)
                REG_IN_CH:  in_ch_reg  <= pwdata[CMM_CNT_W-1:0];
                REG_OUT_CH: out_ch_reg <= pwdata[CMM_CNT_W-1:0];
                REG_MAP_EN: map_en_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (apb_idx)
            REG_IN_CH:  prdata = CMM_PDATA_W'(in_ch_reg);
            REG_OUT_CH: prdata = CMM_PDATA_W'(out_ch_reg);
            REG_MAP_EN: prdata = CMM_PDATA_W'(map_en_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective channel counts: a count of zero acts as one, and both counts are
    // capped at what the hardware was built for.
    logic [CMM_CNT_W-1:0]  nin;
    logic [CMM_CNT_W-1:0]  nout;

    always_comb
    begin
        if (in_ch_reg == '0)
            nin = CMM_CNT_W'(1);
        else if (in_ch_reg > LIM_IN_C)
            nin = LIM_IN_C;
        else
            nin = in_ch_reg;
        if (out_ch_reg == '0)
            nout = CMM_CNT_W'(1);
        else if (out_ch_reg > LIM_OUT_C)
            nout = LIM_OUT_C;
        else
            nout = out_ch_reg;
    end

    // Column map: sixteen four-bit entries, read at the incoming channel.
    logic [CMM_CH_W-1:0]   colmap [CMM_DIM];
    logic                  acc_beat;
    logic                  map_wr;

    assign acc_beat = din.valid && din.ready;
    assign map_wr   = acc_beat && (din.req_type == REQ_MAP);

    always_ff @(posedge clk)
    begin
        if (map_wr)
            colmap[din.in_channel] <= din.coef_col;
    end

    // Request decode. Only a sample inside the frame starts the chain.
    logic                  launch;
    logic                  is_last;
    logic [CMM_CNT_W-1:0]  ch_ext;
    cmm_tok_t              tok_reg;
    cmm_cwr_t              cwr;
    logic                  last_reg;

    assign ch_ext  = CMM_CNT_W'(din.in_channel);
    assign launch  = acc_beat && (din.req_type == REQ_SAMPLE) && (ch_ext < nin);
    assign is_last = (ch_ext == (nin - CMM_CNT_W'(1)));

    assign cwr.en    = acc_beat && (din.req_type == REQ_COEF);
    assign cwr.row   = din.coef_row;
    assign cwr.col   = din.coef_col;
    assign cwr.value = din.coef_value;

    // The launched beat picks its matrix column from the map when the map is on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            tok_reg.valid <= launch;
            if (launch)
            begin
                tok_reg.clr    <= (din.in_channel == '0);
                tok_reg.mac    <= 1'b1;
                tok_reg.col    <= map_en_reg ? colmap[din.in_channel] : din.in_channel;
                tok_reg.sample <= din.sample_value;
                last_reg       <= is_last;
            end
        end
    end

    // The chain of cells. The sample beat moves one cell per cycle; for readout
    // every accumulator moves one cell toward cell 0, and cell 0 wraps to the end,
    // so NCELL steps bring every row back to its own cell.
    cmm_tok_t  tok_chain [NCELL+1];
    acc_t      acc_chain [NCELL];
    logic      rot;

    assign tok_chain[0] = tok_reg;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        cmm_cell #(
            .INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[k]),
            .tok_out (tok_chain[k+1]),
            .cwr     (cwr),
            .nout    (nout),
            .rot     (rot),
            .acc_in  (acc_chain[(k + 1) % NCELL]),
            .acc_out (acc_chain[k])
        );
    end

    // Sequencer: idle, wait for the beat to leave the chain, then read out after the last channel of a frame.
    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CIW-1:0]        rcnt_reg;
    logic [CIW-1:0]        rcnt_next;
    logic                  emit;
    logic                  can_load;
    logic                  step;
    logic                  load;
    logic                  chain_done;

    assign chain_done = tok_chain[NCELL].valid;
    assign emit       = (CMM_CNT_W'(rcnt_reg) < nout);
    assign can_load   = !dout.valid || dout.ready;
    assign step       = (state_reg == ST_DRAIN) && (!emit || can_load);
    assign load       = (state_reg == ST_DRAIN) && emit && can_load;
    assign rot        = step;
    assign din.ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rcnt_next  = rcnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (chain_done)
                begin
                    state_next = last_reg ? ST_DRAIN : ST_IDLE;
                    rcnt_next  = '0;
                end
            end
            ST_DRAIN:
            begin
                if (step)
                begin
                    if (rcnt_reg == RC_LAST)
                        state_next = ST_IDLE;
                    else
                        rcnt_next = rcnt_reg + CIW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    // Output register, loaded from cell 0 through the rounding stage.
    logic                          out_valid_reg;
    logic [CMM_CH_W-1:0]           out_ch_reg_q;
    logic signed [CMM_SMP_W-1:0]   out_smp_reg;
    logic                          out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_ch_reg_q <= CMM_CH_W'(rcnt_reg);
            out_smp_reg  <= cmm_round_sat(acc_chain[0]);
            out_last_reg <= (CMM_CNT_W'(rcnt_reg) == (nout - CMM_CNT_W'(1)));
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.out_channel = out_ch_reg_q;
    assign dout.out_sample  = out_smp_reg;
    assign dout.last_out    = out_last_reg;

    // A sample beat reaches the end of the chain only while the sequencer waits on it.
    `CMM_ASSERT_IMP(a_chain_in_mac, clk, rst_n, chain_done, state_reg == ST_MAC)
    // The beat flagged last carries the highest active output channel.
    `CMM_ASSERT_IMP(a_last_channel, clk, rst_n, dout.valid && dout.last_out,
        CMM_CNT_W'(dout.out_channel) == (nout - CMM_CNT_W'(1)))
    // The final rotation step leaves the ring restored and the sequencer idle.
    `CMM_ASSERT_NXT(a_drain_end, clk, rst_n, step && (rcnt_reg == RC_LAST),
        state_reg == ST_IDLE)
    // A new result never lands on a beat that has not been taken.
    `CMM_ASSERT_IMP(a_no_overwrite, clk, rst_n, load, !out_valid_reg || dout.ready)

endmodule
